/* design/lcru_pkg.sv */
// Package for the lattice coefficient rounding unit.
// Holds the modulus and rounding constants, the action codes and the pipeline payload types.
// No dependencies.
package lcru_pkg;

  // Modulus and derived constants.
  localparam logic [22:0] Q_MOD        = 23'd8380417;
  localparam logic [23:0] HALF_Q       = 24'd4190208;
  localparam logic [22:0] GAMMA2_LOW   = 23'd95232;
  localparam logic [22:0] GAMMA2_HIGH  = 23'd261888;
  localparam logic [22:0] Q_MINUS_G_LO = Q_MOD - GAMMA2_LOW;
  localparam logic [22:0] Q_MINUS_G_HI = Q_MOD - GAMMA2_HIGH;
  localparam logic [19:0] ALPHA_LOW    = 20'd190464;
  localparam logic [19:0] ALPHA_HIGH   = 20'd523776;
  localparam logic [5:0]  TOP_LOW      = 6'd43;
  localparam logic [5:0]  TOP_HIGH     = 6'd15;

  // Reciprocal multipliers for the bucket estimate.
  localparam logic [13:0] RECIP_LOW    = 14'd11275;
  localparam logic [13:0] RECIP_HIGH   = 14'd1025;

  // Power2round parameters.
  localparam int unsigned D_BITS       = 13;
  localparam logic [23:0] P2R_BIAS     = 24'd4095;
  localparam logic [23:0] BUCKET_BIAS  = 24'd127;

  // Configuration register address.
  localparam logic [2:0]  ADDR_GAMMA   = 3'd0;

  typedef enum logic [1:0] {
    ACT_P2R       = 2'd0,
    ACT_DECOMPOSE = 2'd1,
    ACT_MAKE_HINT = 2'd2,
    ACT_USE_HINT  = 2'd3
  } action_t;

  // Payload that leaves the first stage and travels down the pipe.
  typedef struct packed {
    action_t            action;
    logic [22:0]        a;
    logic [15:0]        t;
    logic               hint;
    logic               gmode;
    logic [9:0]         p2r_hi;
    logic signed [18:0] p2r_lo;
    logic               hbit;
  } item_t;

  // Payload at the end of the decompose stages.
  typedef struct packed {
    item_t       item;
    logic [5:0]  h;
    logic [22:0] hm;
  } split_t;

endpackage

/* design/lcru_cfg.sv */
// Configuration register block of the rounding unit: APB-style port with one register.
// Depends on lcru_pkg.
module lcru_cfg
  import lcru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        gamma_mode
);

  logic wr_gamma;

  assign pready   = 1'b1;
  assign wr_gamma = psel && penable && pwrite && (paddr == ADDR_GAMMA);

  // Gamma mode register; writes elsewhere are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_mode <= 1'b0;
    end else if (wr_gamma) begin
      gamma_mode <= pwdata[0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_GAMMA) begin
      prdata[0] = gamma_mode;
    end
  end

endmodule

/* design/lcru_front.sv */
// First pipeline stage: reduces the coefficient, does power2round and make hint,
// and forms the coarse bucket index for decompose. Depends on lcru_pkg.
module lcru_front
  import lcru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        gamma_mode,
  input  logic [1:0]  action,
  input  logic [22:0] coeff,
  input  logic [5:0]  high_in,
  input  logic        hint_in,
  output logic        out_valid,
  output item_t       out_item
);

  logic [23:0]        diff;
  logic [22:0]        a;
  logic [23:0]        tsum;
  logic [23:0]        psum;
  logic [9:0]         phi;
  logic signed [23:0] plo;
  logic [22:0]        g;
  logic [22:0]        qmg;
  logic               zero;
  item_t              item_next;

  // Single conditional subtraction brings the coefficient below Q.
  always_comb begin
    diff = {1'b0, coeff} - {1'b0, Q_MOD};
    a    = diff[23] ? coeff : diff[22:0];
  end

  // Power2round and the bucket estimate share the reduced value.
  always_comb begin
    tsum = {1'b0, a} + BUCKET_BIAS;
    psum = {1'b0, a} + P2R_BIAS;
    phi  = psum[D_BITS+9:D_BITS];
    plo  = $signed({1'b0, a}) - $signed({1'b0, phi, {D_BITS{1'b0}}});
  end

  // Make hint decides from range compares only.
  always_comb begin
    g    = gamma_mode ? GAMMA2_HIGH : GAMMA2_LOW;
    qmg  = gamma_mode ? Q_MINUS_G_HI : Q_MINUS_G_LO;
    zero = (a <= g) || (a > qmg) || ((a == qmg) && (high_in == '0));
  end

  always_comb begin
    item_next.action = action_t'(action);
    item_next.a      = a;
    item_next.t      = tsum[22:7];
    item_next.hint   = hint_in;
    item_next.gmode  = gamma_mode;
    item_next.p2r_hi = phi;
    item_next.p2r_lo = plo[18:0];
    item_next.hbit   = !zero;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= item_next;
    end
  end

endmodule

/* design/lcru_split.sv */
// Decompose stages: reciprocal multiply, bucket rounding with the top-bucket wrap,
// and the multiply back by 2*GAMMA2. Depends on lcru_pkg.
module lcru_split
  import lcru_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  item_t  in_item,
  output logic   out_valid,
  output split_t out_data
);

  // Stage two registers.
  logic        s2_valid;
  item_t       s2_item;
  logic [29:0] s2_prod;

  // Stage three registers.
  logic        s3_valid;
  item_t       s3_item;
  logic [5:0]  s3_h;

  logic [29:0] prod_next;
  logic [30:0] rsum;
  logic [6:0]  h_low;
  logic [5:0]  h_next;
  logic [25:0] hm_full;

  // Reciprocal multiply of the coarse bucket index, at the full product width.
  assign prod_next = {14'd0, in_item.t} *
                     (in_item.gmode ? {16'd0, RECIP_HIGH} : {16'd0, RECIP_LOW});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s2_item <= in_item;
      s2_prod <= prod_next;
    end
  end

  // Round the product to the bucket; the top bucket folds back to zero.
  always_comb begin
    if (s2_item.gmode) begin
      rsum   = {1'b0, s2_prod} + 31'(1 << 21);
      h_low  = '0;
      h_next = {2'b00, rsum[25:22]} & TOP_HIGH;
    end else begin
      rsum   = {1'b0, s2_prod} + 31'(1 << 23);
      h_low  = rsum[30:24];
      h_next = (h_low > {1'b0, TOP_LOW}) ? 6'd0 : h_low[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_item <= s2_item;
      s3_h    <= h_next;
    end
  end

  // Multiply the bucket back by 2*GAMMA2.
  assign hm_full = {20'd0, s3_h} *
                   (s3_item.gmode ? {6'd0, ALPHA_HIGH} : {6'd0, ALPHA_LOW});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      out_data.item <= s3_item;
      out_data.h    <= s3_h;
      out_data.hm   <= hm_full[22:0];
    end
  end

endmodule

/* design/lattice_coefficient_rounding_unit_core.sv */
// Top level of the lattice coefficient rounding unit.
// Depends on lcru_pkg, lcru_cfg, lcru_front and lcru_split.
//
//   Channel   Handshake                          Payload
//   input     start, accepted while busy is low  action, coeff, high_in, hint_in
//   result    done, one-cycle strobe per result  high_out, low_out, hint_out
//   config    psel/penable/pwrite, pready high   paddr, pwdata, prdata
//
// One item enters per cycle; busy stays low since nothing in the pipe ever waits.
// An accepted item passes through these registered stages in order:
// front stage, reciprocal multiply, bucket rounding, multiply back, output stage.
// Synchronous active-high reset empties the pipe and sets gamma_mode to zero.
// The receiver cannot stall, so valid bits simply shift down the pipe each cycle.
module lattice_coefficient_rounding_unit_core
  import lcru_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [22:0]        coeff,
  input  logic [5:0]         high_in,
  input  logic               hint_in,
  output logic               done,
  output logic [9:0]         high_out,
  output logic signed [18:0] low_out,
  output logic               hint_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic               gamma_mode;
  logic               take;
  logic               s1_valid;
  item_t              s1_item;
  logic               s4_valid;
  split_t             s4;

  logic signed [24:0] low_raw;
  logic               big;
  logic signed [24:0] low_adj;
  logic               lpos;
  logic [5:0]         h_fix;
  logic [9:0]         high_next;
  logic signed [18:0] low_next;
  logic               hint_next;

  assign busy = 1'b0;
  assign take = start && !busy;

  lcru_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .gamma_mode(gamma_mode)
  );

  lcru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .gamma_mode(gamma_mode),
    .action    (action),
    .coeff     (coeff),
    .high_in   (high_in),
    .hint_in   (hint_in),
    .out_valid (s1_valid),
    .out_item  (s1_item)
  );

  lcru_split u_split (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_item  (s1_item),
    .out_valid(s4_valid),
    .out_data (s4)
  );

  // Low part with the wrap above Q/2; a wrapped value is never positive.
  always_comb begin
    low_raw = $signed({2'b00, s4.item.a}) - $signed({2'b00, s4.hm});
    big     = low_raw > $signed({1'b0, HALF_Q});
    low_adj = big ? (low_raw - $signed({2'b00, Q_MOD})) : low_raw;
    lpos    = !big && (low_raw > 25'sd0);
  end

  // Hint correction steps the bucket up or down with wraparound.
  always_comb begin
    h_fix = s4.h;
    if (s4.item.hint) begin
      if (s4.item.gmode) begin
        h_fix = lpos ? ((s4.h + 6'd1) & TOP_HIGH) : ((s4.h + TOP_HIGH) & TOP_HIGH);
      end else if (lpos) begin
        h_fix = (s4.h == TOP_LOW) ? 6'd0 : s4.h + 6'd1;
      end else begin
        h_fix = (s4.h == 6'd0) ? TOP_LOW : s4.h - 6'd1;
      end
    end
  end

  // Result select by action.
  always_comb begin
    high_next = '0;
    low_next  = '0;
    hint_next = 1'b0;
    unique case (s4.item.action)
      ACT_P2R: begin
        high_next = s4.item.p2r_hi;
        low_next  = s4.item.p2r_lo;
      end
      ACT_DECOMPOSE: begin
        high_next = {4'b0000, s4.h};
        low_next  = low_adj[18:0];
      end
      ACT_MAKE_HINT: begin
        hint_next = s4.item.hbit;
      end
      ACT_USE_HINT: begin
        high_next = {4'b0000, h_fix};
      end
      default: begin
        high_next = '0;
      end
    endcase
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid) begin
      high_out <= high_next;
      low_out  <= low_next;
      hint_out <= hint_next;
    end
  end

endmodule

/* bench/testbench.sv */
// Self-checking bench for lattice_coefficient_rounding_unit_core. Depends on lcru_pkg.
// Drives a directed table and then random coefficients, checks every result against
// a table value or a local rounding predictor, and reprograms gamma_mode over APB.
module testbench;
  import lcru_pkg::*;

  localparam int PIPE_LATENCY = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 200;
  localparam int MAX_REPORTS  = 40;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  // Arithmetic copies of the package constants, signed and 64 bits wide.
  localparam longint P_Q      = Q_MOD;
  localparam longint P_HALF_Q = HALF_Q;
  localparam longint P_G_LO   = GAMMA2_LOW;
  localparam longint P_G_HI   = GAMMA2_HIGH;
  localparam longint P_TOP_LO = TOP_LOW;
  localparam longint P_TOP_HI = TOP_HIGH;
  localparam longint P_R_LO   = RECIP_LOW;
  localparam longint P_R_HI   = RECIP_HIGH;
  localparam longint P_P2R    = P2R_BIAS;
  localparam longint P_BUCKET = BUCKET_BIAS;
  localparam int     C_MAX    = 8388607;

  typedef struct packed {
    action_t     act;
    logic [22:0] coeff;
    logic [5:0]  high_in;
    logic        hint_in;
  } coeff_item_t;

  typedef struct packed {
    logic [9:0]         high;
    logic signed [18:0] low;
    logic               hint;
  } round_res_t;

  typedef struct {
    logic        gmode;
    coeff_item_t item;
    bit          known;
    round_res_t  res;
  } table_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         action;
  logic [22:0]        coeff;
  logic [5:0]         high_in;
  logic               hint_in;
  logic               done;
  logic [9:0]         high_out;
  logic signed [18:0] low_out;
  logic               hint_out;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  round_res_t expected_rounds[$];
  table_row_t dir_rows[$];
  logic       gamma_model;
  int         accepted_total;
  int         results_seen;
  int         error_count;
  int         cycle_count;
  int         burst_left;
  int         config_writes;
  int         act_count[4];

  lattice_coefficient_rounding_unit_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .coeff(coeff), .high_in(high_in), .hint_in(hint_in),
    .done(done), .high_out(high_out), .low_out(low_out), .hint_out(hint_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decompose bucket estimate with the top-bucket correction; returns the high part.
  function automatic longint bucket_split(input longint a, input logic gm,
                                          output longint lo);
    longint h;
    longint g;
    h = (a + P_BUCKET) >>> 7;
    if (gm) begin
      h = ((h * P_R_HI + (longint'(1) <<< 21)) >>> 22) & P_TOP_HI;
      g = P_G_HI;
    end else begin
      h = (h * P_R_LO + (longint'(1) <<< 23)) >>> 24;
      if (h > P_TOP_LO) h = 0;
      g = P_G_LO;
    end
    lo = a - h * 2 * g;
    if (lo > P_HALF_Q) lo = lo - P_Q;
    return h;
  endfunction

  // Predicts the result of one coefficient under the given gamma mode.
  function automatic round_res_t round_coeff(input coeff_item_t it, input logic gm);
    longint     a;
    longint     g;
    longint     hi;
    longint     lo;
    longint     l;
    round_res_t r;
    a = longint'(it.coeff);
    if (a >= P_Q) a = a - P_Q;
    g = gm ? P_G_HI : P_G_LO;
    hi = 0;
    lo = 0;
    r.hint = 1'b0;
    case (it.act)
      ACT_P2R: begin
        hi = (a + P_P2R) >>> D_BITS;
        lo = a - (hi <<< D_BITS);
      end
      ACT_DECOMPOSE: begin
        hi = bucket_split(a, gm, lo);
      end
      ACT_MAKE_HINT: begin
        r.hint = !((a <= g) || (a > P_Q - g) || (a == P_Q - g && it.high_in == 6'd0));
      end
      default: begin
        hi = bucket_split(a, gm, l);
        if (it.hint_in) begin
          if (gm) begin
            hi = (l > 0) ? ((hi + 1) & P_TOP_HI) : ((hi + P_TOP_HI) & P_TOP_HI);
          end else if (l > 0) begin
            hi = (hi == P_TOP_LO) ? 0 : hi + 1;
          end else begin
            hi = (hi == 0) ? P_TOP_LO : hi - 1;
          end
        end
      end
    endcase
    r.high = hi[9:0];
    r.low  = lo[18:0];
    return r;
  endfunction

  function automatic table_row_t dir_row(input logic gm, input action_t act, input int c,
                                         input int hin, input bit hnt, input bit known,
                                         input int eh, input int el, input bit eht);
    table_row_t row;
    row.gmode        = gm;
    row.item.act     = act;
    row.item.coeff   = c[22:0];
    row.item.high_in = hin[5:0];
    row.item.hint_in = hnt;
    row.known        = known;
    row.res.high     = eh[9:0];
    row.res.low      = el[18:0];
    row.res.hint     = eht;
    return row;
  endfunction

  // Random coefficient, weighted toward range ends and rounding boundaries.
  function automatic logic [22:0] random_coeff(input action_t act, input logic gm);
    int c;
    int g;
    int k;
    g = gm ? int'(P_G_HI) : int'(P_G_LO);
    case ($urandom_range(0, 9))
      0: c = $urandom_range(int'(P_Q), C_MAX);
      1: c = $urandom_range(0, 400);
      2: c = int'(P_Q) - 1 - int'($urandom_range(0, 400));
      3, 4: begin
        if (act == ACT_P2R) begin
          c = $urandom_range(0, 1022) * 8192 + 4096 + int'($urandom_range(0, 8)) - 4;
        end else begin
          k = $urandom_range(0, gm ? 15 : 43);
          c = (2 * k + int'($urandom_range(0, 1))) * g + int'($urandom_range(0, 8)) - 4;
        end
      end
      5: c = ($urandom_range(0, 1) ? g : int'(P_Q) - g) + int'($urandom_range(0, 8)) - 4;
      default: c = $urandom_range(0, int'(P_Q) - 1);
    endcase
    if (c < 0) c = 0;
    if (c > C_MAX) c = C_MAX;
    return c[22:0];
  endfunction

  // Count accepted transfers; the driver reads this at the falling edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) accepted_total++;
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    round_res_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_rounds.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected: high %0d low %0d hint %0b",
                   $time, high_out, low_out, hint_out);
      end else begin
        want = expected_rounds.pop_front();
        if (high_out !== want.high || low_out !== want.low || hint_out !== want.hint) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected high %0d low %0d hint %0b, got high %0d low %0d hint %0b",
                     $time, want.high, want.low, want.hint, high_out, low_out, hint_out);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lattice_coefficient_rounding_unit_core test failed");
      $finish;
    end
  end

  // Present one item, wait for its transfer and queue what it should produce.
  task automatic send_item(input coeff_item_t it, input bit known, input round_res_t kres);
    int gap;
    int seen;
    if (burst_left == 0) begin
      start = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    action  = it.act;
    coeff   = it.coeff;
    high_in = it.high_in;
    hint_in = it.hint_in;
    start   = 1'b1;
    seen    = accepted_total;
    do @(negedge clk); while (accepted_total == seen);
    expected_rounds.push_back(known ? kres : round_coeff(it, gamma_model));
    act_count[it.act]++;
    burst_left--;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain_pipe();
    int waited;
    start = 1'b0;
    waited = 0;
    while (expected_rounds.size() != 0 && waited < 200) begin
      @(negedge clk);
      waited++;
    end
    if (expected_rounds.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_rounds.size());
      expected_rounds.delete();
    end
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Read gamma_mode back and compare with the local copy.
  task automatic check_gamma_readback();
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_GAMMA;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== {31'd0, gamma_model}) begin
      error_count++;
      $display("%0t: gamma_mode readback: expected %0h, got %0h", $time,
               {31'd0, gamma_model}, got);
    end
  endtask

  task automatic set_gamma(input logic gm);
    logic [31:0] data;
    drain_pipe();
    data = $urandom;
    data[0] = gm;
    apb_write(ADDR_GAMMA, data);
    gamma_model = gm;
    config_writes++;
    check_gamma_readback();
  endtask

  initial begin
    coeff_item_t it;
    round_res_t  none;
    logic        phase_gamma[RAND_PHASES];
    logic [31:0] data;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_P2R;
    coeff = '0;
    high_in = '0;
    hint_in = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gamma_model = 1'b0;
    accepted_total = 0;
    results_seen = 0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    config_writes = 0;
    none = '0;
    for (int i = 0; i < 4; i++) act_count[i] = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_gamma_readback();

    // Directed table: range ends, values at and above Q, bucket edges and both hints.
    dir_rows.push_back(dir_row(0, ACT_P2R, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_P2R, 8380416, 43, 1, 1, 1023, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_P2R, 8380417, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_P2R, C_MAX, 63, 1, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_P2R, 4096, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_DECOMPOSE, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_DECOMPOSE, 8380416, 0, 1, 1, 0, -1, 0));
    dir_rows.push_back(dir_row(0, ACT_DECOMPOSE, 95232, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_DECOMPOSE, 95233, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_DECOMPOSE, 8285184, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_MAKE_HINT, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_MAKE_HINT, 95233, 5, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_MAKE_HINT, 8285185, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_MAKE_HINT, 8285185, 63, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_USE_HINT, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_USE_HINT, 8380416, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ACT_USE_HINT, 95233, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ACT_DECOMPOSE, 8380416, 0, 0, 1, 0, -1, 0));
    dir_rows.push_back(dir_row(1, ACT_DECOMPOSE, 261888, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ACT_DECOMPOSE, 261889, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ACT_MAKE_HINT, 261889, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ACT_MAKE_HINT, 8118529, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ACT_USE_HINT, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ACT_USE_HINT, C_MAX, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ACT_P2R, C_MAX, 63, 1, 0, 0, 0, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].gmode != gamma_model) set_gamma(dir_rows[i].gmode);
      send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].res);
    end

    // Random phases under several gamma settings, both extremes included.
    phase_gamma[0] = 1'b0;
    phase_gamma[1] = 1'b1;
    phase_gamma[2] = 1'b1;
    phase_gamma[3] = 1'b0;
    phase_gamma[4] = 1'b1;
    phase_gamma[5] = $urandom_range(0, 1);
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_gamma(phase_gamma[p]);
      if (p == 3) begin
        // A write to an address past the register must leave gamma_mode alone.
        data = $urandom;
        data[0] = ~gamma_model;
        apb_write(ADDR_UNUSED, data);
        check_gamma_readback();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.act     = action_t'($urandom_range(0, 3));
        it.coeff   = random_coeff(it.act, gamma_model);
        it.high_in = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
        it.hint_in = $urandom_range(0, 1);
        send_item(it, 1'b0, none);
      end
    end

    drain_pipe();
    $display("Sent %0d coefficients (p2r %0d, decompose %0d, make hint %0d, use hint %0d).",
             accepted_total, act_count[0], act_count[1], act_count[2], act_count[3]);
    $display("Checked %0d results across %0d gamma_mode writes; %0d errors.",
             results_seen, config_writes, error_count);
    if (error_count == 0) begin
      $display("lattice_coefficient_rounding_unit_core test passed");
    end else begin
      $display("lattice_coefficient_rounding_unit_core test failed");
    end
    $finish;
  end

endmodule

/* lattice_coefficient_rounding_unit_core.f */
design/lcru_pkg.sv
design/lcru_cfg.sv
design/lcru_front.sv
design/lcru_split.sv
design/lattice_coefficient_rounding_unit_core.sv
bench/testbench.sv
